>>> rtl/core/sobel_edge_nonmax_suppress_macros.svh
// ----------------------------------------------------------------------------
// Sobel edge NMS assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_NONMAX_SUPPRESS_MACROS_SVH
`define SOBEL_EDGE_NONMAX_SUPPRESS_MACROS_SVH

// same-cycle implication
`define SEN_ASSERT_IMP(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SEN_ASSERT_NXT(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sen_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge NMS package
// Beat types, register and target codes, control/status bundles.
// ----------------------------------------------------------------------------
package sen_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_ROWS  = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int CNT_W      = COL_W + ROW_W;

    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WEAK_THR     = 2'd2;
    localparam logic [1:0] CFG_STRONG_THR   = 2'd3;

    localparam logic [1:0] TGT_CENTER = 2'd0;
    localparam logic [1:0] TGT_NEAR   = 2'd1;
    localparam logic [1:0] TGT_FAR    = 2'd2;

    localparam logic [1:0] SQ_X = 2'd0;
    localparam logic [1:0] SQ_Y = 2'd1;
    localparam logic [1:0] SQ_S = 2'd2;

    localparam logic [1:0] STR_NONE   = 2'd0;
    localparam logic [1:0] STR_WEAK   = 2'd1;
    localparam logic [1:0] STR_STRONG = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flush;
    } pix_t;

    typedef struct packed {
        logic        thin_edge;
        logic [1:0]  strength;
        logic [10:0] magnitude;
        logic [1:0]  sector;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       cfg_we;
        logic       accept;
        logic [1:0] tgt;
        logic       center_chk;
        logic       grad_clear;
        logic       grad_read;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       store;
        logic       store_zero;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic emit_req;
        logic tgt_interior;
        logic tap_last;
        logic root_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/sen_ctrl.sv
// ----------------------------------------------------------------------------
// Sobel edge NMS controller
// Sequences the gradient, squaring and root passes for one result.
// ----------------------------------------------------------------------------
module sen_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    input  logic            cfg_valid,
    output logic            pix_stall,
    output logic            cfg_ready,
    input  sen_pkg::sts_t   sts,
    output sen_pkg::cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_NB    = 4'd2;
    localparam logic [3:0] ST_GRAD  = 4'd3;
    localparam logic [3:0] ST_GLAST = 4'd4;
    localparam logic [3:0] ST_SQX   = 4'd5;
    localparam logic [3:0] ST_SQY   = 4'd6;
    localparam logic [3:0] ST_SQS   = 4'd7;
    localparam logic [3:0] ST_RINIT = 4'd8;
    localparam logic [3:0] ST_ROOT  = 4'd9;
    localparam logic [3:0] ST_STORE = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] tgt_reg;
    logic [1:0] tgt_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign pix_stall = (state_reg != ST_IDLE) || cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        cmd        = '0;
        cmd.tgt    = tgt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_we = cfg_valid;
                if (pix_valid && !cfg_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.emit_req)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                cmd.tgt        = sen_pkg::TGT_CENTER;
                cmd.center_chk = 1'b1;
                cmd.grad_clear = 1'b1;
                tgt_next       = sen_pkg::TGT_CENTER;
                state_next     = sts.tgt_interior ? ST_GRAD : ST_FIN;
            end
            ST_NB:
            begin
                cmd.grad_clear = 1'b1;
                if (sts.tgt_interior)
                begin
                    state_next = ST_GRAD;
                end
                else
                begin
                    cmd.store      = 1'b1;
                    cmd.store_zero = 1'b1;
                    if (tgt_reg == sen_pkg::TGT_NEAR)
                    begin
                        tgt_next = sen_pkg::TGT_FAR;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_GRAD:
            begin
                cmd.grad_read = 1'b1;
                if (sts.tap_last)
                begin
                    state_next = ST_GLAST;
                end
            end
            ST_GLAST:
            begin
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sq_sel = sen_pkg::SQ_X;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sq_sel = sen_pkg::SQ_Y;
                state_next = (tgt_reg == sen_pkg::TGT_CENTER) ? ST_SQS : ST_RINIT;
            end
            ST_SQS:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sq_sel = sen_pkg::SQ_S;
                state_next = ST_RINIT;
            end
            ST_RINIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (tgt_reg == sen_pkg::TGT_CENTER)
                begin
                    tgt_next   = sen_pkg::TGT_NEAR;
                    state_next = ST_NB;
                end
                else if (tgt_reg == sen_pkg::TGT_NEAR)
                begin
                    tgt_next   = sen_pkg::TGT_FAR;
                    state_next = ST_NB;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tgt_reg   <= sen_pkg::TGT_CENTER;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
        end
    end

endmodule

>>> rtl/core/sen_dp.sv
// ----------------------------------------------------------------------------
// Sobel edge NMS datapath
// Gray ring store, position counters, gradient accumulator, squarer,
// bit-pair square root and result register.
// ----------------------------------------------------------------------------
module sen_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sen_pkg::cmd_t         cmd,
    output sen_pkg::sts_t         sts,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    input  sen_pkg::pix_t         pix_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output sen_pkg::res_t         res_data
);

    localparam int COL_W  = sen_pkg::COL_W;
    localparam int ROW_W  = sen_pkg::ROW_W;
    localparam int CNT_W  = sen_pkg::CNT_W;
    localparam int RING_W = sen_pkg::RING_W;
    localparam int DEPTH  = sen_pkg::RING_ROWS * sen_pkg::MAX_WIDTH;

    // configuration
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [10:0] weak_reg;
    logic [10:0] strong_reg;
    logic [10:0] w_eff;
    logic [12:0] h_eff;

    // positions
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [CNT_W-1:0] rcv_reg;
    logic [CNT_W-1:0] emit_cnt_reg;
    logic [ROW_W-1:0] e_row_reg;
    logic [COL_W-1:0] e_col_reg;
    logic             drain_reg;

    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic             img_wrap;
    logic [CNT_W:0]   rcv_inc;
    logic [CNT_W:0]   emit_thr;
    logic             emit_pix;
    logic [COL_W:0]   e_col_inc;
    logic [ROW_W:0]   e_row_inc;
    logic             e_cwrap;
    logic             e_last;

    // gray store
    logic [7:0]       gray_mem [DEPTH];
    logic [9:0]       rgb_sum;
    logic [19:0]      gray_prod;
    logic [7:0]       gray_val;
    logic [7:0]       mem_q;

    // target and taps
    logic signed [1:0] di;
    logic signed [1:0] dj;
    logic [ROW_W-1:0] ta;
    logic [COL_W-1:0] tb;
    logic [1:0]       tap_r_reg;
    logic [1:0]       tap_c_reg;
    logic [1:0]       tap_dr_reg;
    logic [1:0]       tap_dc_reg;
    logic             acc_en_reg;
    logic [RING_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
    logic signed [11:0] gx_reg;
    logic signed [11:0] gy_reg;
    logic signed [11:0] tap_x2;
    logic signed [11:0] tap_x1;

    // squaring and root
    logic [10:0]      ax;
    logic [10:0]      ay;
    logic [11:0]      s_sum;
    logic [10:0]      sq_op;
    logic [21:0]      sq_prod;
    logic [19:0]      ax2_reg;
    logic [19:0]      ay2_reg;
    logic [21:0]      ss_reg;
    logic [20:0]      v_reg;
    logic [20:0]      rt_reg;
    logic [20:0]      bit_reg;
    logic [21:0]      rt_try;
    logic [1:0]       sector_calc;

    // result
    logic [10:0]      mag_reg;
    logic [10:0]      n1_reg;
    logic [10:0]      n2_reg;
    logic [1:0]       sector_reg;
    logic             ctr_int_reg;
    logic             res_valid_reg;
    sen_pkg::res_t    res_reg;
    sen_pkg::res_t    res_next;

    assign w_eff = (width_reg < 11'd3) ? 11'd3 :
                   (width_reg > 11'(sen_pkg::MAX_WIDTH)) ? 11'(sen_pkg::MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg < 13'd3) ? 13'd3 :
                   (height_reg > 13'(sen_pkg::MAX_HEIGHT)) ? 13'(sen_pkg::MAX_HEIGHT) :
                   height_reg;

    assign col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign row_inc  = {1'b0, in_row_reg} + 1'b1;
    assign col_wrap = (col_inc == w_eff);
    assign img_wrap = col_wrap && (row_inc == h_eff);
    assign rcv_inc  = {1'b0, rcv_reg} + 1'b1;
    assign emit_thr = (drain_reg ? '0 : {1'b0, emit_cnt_reg})
                      + {{(CNT_W - 11){1'b0}}, w_eff, 1'b0} + (CNT_W+1)'(3);
    assign emit_pix = img_wrap || (emit_thr <= rcv_inc);

    assign e_col_inc = {1'b0, e_col_reg} + 1'b1;
    assign e_row_inc = {1'b0, e_row_reg} + 1'b1;
    assign e_cwrap   = (e_col_inc == w_eff);
    assign e_last    = e_cwrap && (e_row_inc == h_eff);

    assign rgb_sum   = {2'b00, pix_data.red} + {2'b00, pix_data.green}
                       + {2'b00, pix_data.blue};
    assign gray_prod = 20'(rgb_sum) * 20'(sen_pkg::GRAY_RECIP);
    assign gray_val  = gray_prod[sen_pkg::GRAY_SHIFT +: 8];

    always_comb
    begin
        di = 2'sd0;
        dj = 2'sd0;
        if (cmd.tgt != sen_pkg::TGT_CENTER)
        begin
            case (sector_reg)
                2'd0:
                begin
                    di = (cmd.tgt == sen_pkg::TGT_NEAR) ? -2'sd1 : 2'sd1;
                end
                2'd1:
                begin
                    di = (cmd.tgt == sen_pkg::TGT_NEAR) ? 2'sd1 : -2'sd1;
                    dj = (cmd.tgt == sen_pkg::TGT_NEAR) ? -2'sd1 : 2'sd1;
                end
                2'd2:
                begin
                    dj = (cmd.tgt == sen_pkg::TGT_NEAR) ? -2'sd1 : 2'sd1;
                end
                default:
                begin
                    di = (cmd.tgt == sen_pkg::TGT_NEAR) ? 2'sd1 : -2'sd1;
                    dj = (cmd.tgt == sen_pkg::TGT_NEAR) ? 2'sd1 : -2'sd1;
                end
            endcase
        end
    end

    assign ta = e_row_reg + {{(ROW_W - 2){di[1]}}, di};
    assign tb = e_col_reg + {{(COL_W - 2){dj[1]}}, dj};

    assign rd_row = ta[RING_W-1:0] + RING_W'(tap_r_reg) - 1'b1;
    assign rd_col = tb + COL_W'(tap_c_reg) - 1'b1;

    assign tap_x2 = (tap_dc_reg == 2'd1) ? $signed({3'b000, mem_q, 1'b0})
                                         : $signed({4'b0000, mem_q});
    assign tap_x1 = (tap_dr_reg == 2'd1) ? $signed({3'b000, mem_q, 1'b0})
                                         : $signed({4'b0000, mem_q});

    assign ax    = gx_reg[11] ? 11'(-gx_reg) : gx_reg[10:0];
    assign ay    = gy_reg[11] ? 11'(-gy_reg) : gy_reg[10:0];
    assign s_sum = {1'b0, ax} + {1'b0, ay};
    always_comb
    begin
        case (cmd.sq_sel)
            sen_pkg::SQ_X: sq_op = ax;
            sen_pkg::SQ_Y: sq_op = ay;
            default:       sq_op = s_sum[10:0];
        endcase
    end
    assign sq_prod = 22'(sq_op) * 22'(sq_op);

    assign rt_try = {1'b0, rt_reg} + {1'b0, bit_reg};

    always_comb
    begin
        if ((gx_reg == 12'sd0) || (gy_reg == 12'sd0) || (ax == ay))
        begin
            sector_calc = 2'd0;
        end
        else if (ss_reg < {1'b0, ax2_reg, 1'b0})
        begin
            sector_calc = 2'd0;
        end
        else if (ss_reg < {1'b0, ay2_reg, 1'b0})
        begin
            sector_calc = 2'd2;
        end
        else
        begin
            sector_calc = (gx_reg[11] == gy_reg[11]) ? 2'd1 : 2'd3;
        end
    end

    assign sts.emit_req     = pix_data.flush ? drain_reg : emit_pix;
    assign sts.tgt_interior = (ta != '0) && (({1'b0, ta} + 1'b1) < h_eff)
                              && (tb != '0) && (({1'b0, tb} + 1'b1) < w_eff);
    assign sts.tap_last     = (tap_r_reg == 2'd2) && (tap_c_reg == 2'd2);
    assign sts.root_last    = bit_reg[0];
    assign sts.out_free     = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_next           = '0;
        res_next.last      = e_last;
        if (ctr_int_reg)
        begin
            res_next.thin_edge = (mag_reg > n1_reg) && (mag_reg > n2_reg);
            res_next.magnitude = mag_reg;
            res_next.sector    = sector_reg;
            if (mag_reg >= strong_reg)
            begin
                res_next.strength = sen_pkg::STR_STRONG;
            end
            else if (mag_reg >= weak_reg)
            begin
                res_next.strength = sen_pkg::STR_WEAK;
            end
            else
            begin
                res_next.strength = sen_pkg::STR_NONE;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // config and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 11'd640;
            height_reg   <= 13'd480;
            weak_reg     <= 11'd70;
            strong_reg   <= 11'd90;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            rcv_reg      <= '0;
            emit_cnt_reg <= '0;
            e_row_reg    <= '0;
            e_col_reg    <= '0;
            drain_reg    <= 1'b0;
        end
        else if (cmd.cfg_we)
        begin
            unique case (cfg_index)
                sen_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[10:0];
                sen_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                sen_pkg::CFG_WEAK_THR:     weak_reg   <= cfg_data[10:0];
                sen_pkg::CFG_STRONG_THR:   strong_reg <= cfg_data[10:0];
                default:                   weak_reg   <= weak_reg;
            endcase
            if ((cfg_index == sen_pkg::CFG_IMAGE_WIDTH)
                || (cfg_index == sen_pkg::CFG_IMAGE_HEIGHT))
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                rcv_reg      <= '0;
                emit_cnt_reg <= '0;
                e_row_reg    <= '0;
                e_col_reg    <= '0;
                drain_reg    <= 1'b0;
            end
        end
        else if (cmd.accept && !pix_data.flush)
        begin
            if (drain_reg)
            begin
                emit_cnt_reg <= '0;
                e_row_reg    <= '0;
                e_col_reg    <= '0;
            end
            in_col_reg <= col_wrap ? '0 : col_inc[COL_W-1:0];
            if (col_wrap)
            begin
                in_row_reg <= img_wrap ? '0 : row_inc[ROW_W-1:0];
            end
            rcv_reg   <= img_wrap ? '0 : rcv_inc[CNT_W-1:0];
            drain_reg <= img_wrap;
        end
        else if (cmd.fin)
        begin
            if (e_last)
            begin
                emit_cnt_reg <= '0;
                e_row_reg    <= '0;
                e_col_reg    <= '0;
                drain_reg    <= 1'b0;
            end
            else
            begin
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
                e_col_reg    <= e_cwrap ? '0 : e_col_inc[COL_W-1:0];
                if (e_cwrap)
                begin
                    e_row_reg <= e_row_inc[ROW_W-1:0];
                end
            end
        end
    end

    // gray ring store
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !pix_data.flush)
        begin
            gray_mem[{in_row_reg[RING_W-1:0], in_col_reg}] <= gray_val;
        end
        if (cmd.grad_read)
        begin
            mem_q <= gray_mem[{rd_row, rd_col}];
        end
    end

    // tap sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_r_reg  <= '0;
            tap_c_reg  <= '0;
            acc_en_reg <= 1'b0;
        end
        else if (cmd.grad_clear)
        begin
            tap_r_reg  <= '0;
            tap_c_reg  <= '0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.grad_read;
            if (cmd.grad_read)
            begin
                if (tap_c_reg == 2'd2)
                begin
                    tap_c_reg <= '0;
                    tap_r_reg <= tap_r_reg + 1'b1;
                end
                else
                begin
                    tap_c_reg <= tap_c_reg + 1'b1;
                end
            end
        end
    end

    // gradient, squares, root, stored results
    always_ff @(posedge clk)
    begin
        if (cmd.grad_read)
        begin
            tap_dr_reg <= tap_r_reg;
            tap_dc_reg <= tap_c_reg;
        end
        if (cmd.grad_clear)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            if (tap_dr_reg == 2'd2)
            begin
                gx_reg <= gx_reg + tap_x2;
            end
            else if (tap_dr_reg == 2'd0)
            begin
                gx_reg <= gx_reg - tap_x2;
            end
            if (tap_dc_reg == 2'd2)
            begin
                gy_reg <= gy_reg + tap_x1;
            end
            else if (tap_dc_reg == 2'd0)
            begin
                gy_reg <= gy_reg - tap_x1;
            end
        end
        if (cmd.sq_en)
        begin
            case (cmd.sq_sel)
                sen_pkg::SQ_X: ax2_reg <= sq_prod[19:0];
                sen_pkg::SQ_Y: ay2_reg <= sq_prod[19:0];
                default:       ss_reg  <= sq_prod;
            endcase
        end
        if (cmd.root_init)
        begin
            v_reg   <= {1'b0, ax2_reg} + {1'b0, ay2_reg};
            rt_reg  <= '0;
            bit_reg <= 21'h100000;
        end
        else if (cmd.root_step)
        begin
            if ({1'b0, v_reg} >= rt_try)
            begin
                v_reg  <= v_reg - rt_try[20:0];
                rt_reg <= (rt_reg >> 1) + bit_reg;
            end
            else
            begin
                rt_reg <= rt_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.center_chk)
        begin
            ctr_int_reg <= sts.tgt_interior;
        end
        if (cmd.store)
        begin
            case (cmd.tgt)
                sen_pkg::TGT_CENTER:
                begin
                    mag_reg    <= rt_reg[10:0];
                    sector_reg <= sector_calc;
                end
                sen_pkg::TGT_NEAR: n1_reg <= cmd.store_zero ? '0 : rt_reg[10:0];
                default:           n2_reg <= cmd.store_zero ? '0 : rt_reg[10:0];
            endcase
        end
        if (cmd.fin)
        begin
            res_reg <= res_next;
        end
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/sobel_edge_nonmax_suppress.sv
// Pixel beats that produce no result do not hold the input. A beat that
// produces a result holds the input until that result is registered; on an
// interior pixel this spans up to three 9-tap gradient passes over one gray
// store port, each followed by an 11-step square root. Results appear 2*W+2
// pixels behind. Reset is asynchronous, active low; it restores default
// registers, clears all positions and drops any waiting result.
// ----------------------------------------------------------------------------
// Sobel edge NMS top level
// Gray conversion, Sobel magnitude, strength class and non-maximum
// suppression over a raster pixel stream.
// ----------------------------------------------------------------------------
module sobel_edge_nonmax_suppress (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    output logic            pix_stall,
    input  sen_pkg::pix_t   pix_data,
    output logic            res_valid,
    input  logic            res_stall,
    output sen_pkg::res_t   res_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [12:0]     cfg_data
);

    sen_pkg::cmd_t cmd;
    sen_pkg::sts_t sts;

    sen_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .cfg_valid (cfg_valid),
        .pix_stall (pix_stall),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sen_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

>>> rtl/core/sen_checker.sv
// ----------------------------------------------------------------------------
// Sobel edge NMS port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "sobel_edge_nonmax_suppress_macros.svh"

module sen_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pix_stall,
    input logic            res_valid,
    input logic            res_stall,
    input sen_pkg::res_t   res_data,
    input logic            cfg_valid,
    input logic            cfg_ready
);

    `SEN_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "result beat changed while stalled")
    `SEN_ASSERT_IMP(a_cfg_excl, cfg_valid && cfg_ready, pix_stall, "pixel taken with a config write")
    `SEN_ASSERT_IMP(a_thin_mag, res_valid && res_data.thin_edge, res_data.magnitude != 11'd0, "thin edge with zero magnitude")
    `SEN_ASSERT_IMP(a_sector_mag, res_valid && (res_data.sector != 2'd0), res_data.magnitude != 11'd0, "sector set with zero magnitude")

endmodule

bind sobel_edge_nonmax_suppress sen_checker u_sen_checker (.*);
